// ===== hdl/packet_slot_fifo_assert.svh =====
// Assertion macros for the packet slot FIFO; included by the back end.
`ifndef PACKET_SLOT_FIFO_ASSERT_SVH
`define PACKET_SLOT_FIFO_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/psf_pkg.sv =====
// Types, constants and helpers for the packet slot FIFO.
package psf_pkg;

  localparam int unsigned SLOTS            = 64;
  localparam int unsigned MAX_PACKET_BYTES = 64;

  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned OCC_W   = $clog2(SLOTS + 1);
  localparam int unsigned CNT_W   = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned IDX_W   = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
  localparam int unsigned ADDR_W  = $clog2(SLOTS * MAX_PACKET_BYTES);
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_TRUNC = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_PUSH_END = 2'd1,
    OP_POP      = 2'd2
  } op_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             last;
    logic [LEN_W-1:0] packet_length;
  } out_item_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       has_byte;
  } cmd_t;

  // First byte address of a slot in the payload store.
  function automatic logic [ADDR_W-1:0] slot_base(logic [SLOT_W-1:0] slot);
    return ADDR_W'(slot) * ADDR_W'(MAX_PACKET_BYTES);
  endfunction

endpackage

// ===== hdl/psf_front.sv =====
// Front end: accepts beats, classifies them and queues commands for the back end.
module psf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  psf_pkg::in_item_t in_i,
  output logic            cmd_valid_o,
  output psf_pkg::cmd_t   cmd_o,
  input  logic            cmd_take_i
);
  import psf_pkg::*;

  cmd_t            q_mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_AW:0]   cnt_q, cnt_d;
  logic            push, pop;
  cmd_t            cmd_new;

  assign busy        = (cnt_q == (Q_AW + 1)'(Q_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = start && !busy;
  assign pop         = cmd_take_i && cmd_valid_o;

  always_comb begin
    if (in_i.kind == KIND_POP) begin
      cmd_new.op = OP_POP;
    end else if (in_i.last_byte) begin
      cmd_new.op = OP_PUSH_END;
    end else begin
      cmd_new.op = OP_PUSH;
    end
    cmd_new.data     = in_i.data_byte;
    cmd_new.has_byte = in_i.has_byte;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== hdl/psf_back.sv =====
// Back end: slot ring, payload and length stores, push commit and pop streaming.
`include "packet_slot_fifo_assert.svh"

module psf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  psf_pkg::cmd_t      cmd_i,
  output logic               cmd_take_o,
  output logic               res_valid_o,
  output psf_pkg::out_item_t res_o
);
  import psf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_BYTE
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] ws_q, ws_d;
  logic [SLOT_W-1:0] rs_q, rs_d;
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ia_q, ia_d;
  logic              rej_q, rej_d;
  logic              trunc_q, trunc_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              res_valid_q, res_valid_d;
  out_item_t         res_q, res_d;

  logic [7:0]        byte_mem [SLOTS * MAX_PACKET_BYTES];
  logic [CNT_W-1:0]  len_mem  [SLOTS];
  logic [7:0]        byte_rd_q;
  logic [CNT_W-1:0]  len_rd_q;

  logic              byte_we;
  logic [ADDR_W-1:0] byte_waddr;
  logic [ADDR_W-1:0] byte_raddr;
  logic              len_we;
  logic [CNT_W-1:0]  len_wdata;
  logic              cmd_take;
  logic              byte_last;

  assign cmd_take_o  = cmd_take;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign byte_last   = ((CNT_W'(idx_q) + CNT_W'(1)) == len_q);

  always_comb begin
    logic             rej_c;
    logic             trunc_c;
    logic [CNT_W-1:0] cnt_c;

    state_d     = state_q;
    ws_d        = ws_q;
    rs_d        = rs_q;
    cur_d       = cur_q;
    occ_d       = occ_q;
    cnt_d       = cnt_q;
    ia_d        = ia_q;
    rej_d       = rej_q;
    trunc_d     = trunc_q;
    len_d       = len_q;
    idx_d       = idx_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    cmd_take    = 1'b0;
    byte_we     = 1'b0;
    byte_waddr  = slot_base(ws_q);
    byte_raddr  = slot_base(cur_q);
    len_we      = 1'b0;
    len_wdata   = cnt_q;

    // A packet's first beat samples the ring; later beats keep the stored flags.
    rej_c   = ia_q ? rej_q   : (occ_q == OCC_W'(SLOTS));
    trunc_c = ia_q ? trunc_q : 1'b0;
    cnt_c   = ia_q ? cnt_q   : '0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take = 1'b1;
          if (cmd_i.op == OP_POP) begin
            if (occ_q == '0) begin
              res_valid_d = 1'b1;
              res_d       = '{status: ST_EMPTY, out_byte: 8'd0, byte_valid: 1'b0,
                              last: 1'b1, packet_length: '0};
            end else begin
              cur_d   = rs_q;
              rs_d    = (rs_q == SLOT_W'(SLOTS - 1)) ? '0 : rs_q + 1'b1;
              occ_d   = occ_q - 1'b1;
              state_d = S_LEN;
            end
          end else begin
            if (cmd_i.has_byte && !rej_c) begin
              if (cnt_c < CNT_W'(MAX_PACKET_BYTES)) begin
                byte_we    = 1'b1;
                byte_waddr = slot_base(ws_q) + ADDR_W'(cnt_c[IDX_W-1:0]);
                cnt_c      = cnt_c + 1'b1;
              end else begin
                // drop the excess byte
                trunc_c = 1'b1;
              end
            end
            if (cmd_i.op == OP_PUSH_END) begin
              ia_d        = 1'b0;
              res_valid_d = 1'b1;
              if (rej_c) begin
                res_d = '{status: ST_BUSY, out_byte: 8'd0, byte_valid: 1'b0,
                          last: 1'b1, packet_length: '0};
              end else begin
                len_we    = 1'b1;
                len_wdata = cnt_c;
                ws_d      = (ws_q == SLOT_W'(SLOTS - 1)) ? '0 : ws_q + 1'b1;
                occ_d     = occ_q + 1'b1;
                res_d     = '{status: (trunc_c ? ST_TRUNC : ST_OK), out_byte: 8'd0,
                              byte_valid: 1'b0, last: 1'b1,
                              packet_length: LEN_W'(cnt_c)};
              end
            end else begin
              ia_d    = 1'b1;
              rej_d   = rej_c;
              trunc_d = trunc_c;
              cnt_d   = cnt_c;
            end
          end
        end
      end
      S_LEN: begin
        if (len_rd_q == '0) begin
          res_valid_d = 1'b1;
          res_d       = '{status: ST_OK, out_byte: 8'd0, byte_valid: 1'b0,
                          last: 1'b1, packet_length: '0};
          state_d     = S_IDLE;
        end else begin
          len_d      = len_rd_q;
          idx_d      = '0;
          byte_raddr = slot_base(cur_q);
          state_d    = S_BYTE;
        end
      end
      S_BYTE: begin
        res_valid_d = 1'b1;
        res_d       = '{status: ST_OK, out_byte: byte_rd_q, byte_valid: 1'b1,
                        last: byte_last, packet_length: LEN_W'(len_q)};
        if (byte_last) begin
          state_d = S_IDLE;
        end else begin
          // advance and fetch the next byte
          idx_d      = idx_q + 1'b1;
          byte_raddr = slot_base(cur_q) + ADDR_W'(idx_q + 1'b1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ws_q        <= '0;
      rs_q        <= '0;
      cur_q       <= '0;
      occ_q       <= '0;
      cnt_q       <= '0;
      ia_q        <= 1'b0;
      rej_q       <= 1'b0;
      trunc_q     <= 1'b0;
      len_q       <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      ws_q        <= ws_d;
      rs_q        <= rs_d;
      cur_q       <= cur_d;
      occ_q       <= occ_d;
      cnt_q       <= cnt_d;
      ia_q        <= ia_d;
      rej_q       <= rej_d;
      trunc_q     <= trunc_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      byte_mem[byte_waddr] <= cmd_i.data;
    end
    byte_rd_q <= byte_mem[byte_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[ws_q] <= len_wdata;
    end
    len_rd_q <= len_mem[rs_q];
  end

  `PSF_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= OCC_W'(SLOTS), "occupancy exceeds ring size")
  `PSF_ASSERT_NXT(a_pop_fetch,
                  state_q == S_IDLE && cmd_take && cmd_i.op == OP_POP && occ_q != '0,
                  state_q == S_LEN, "pop of a filled ring did not fetch its length")
  `PSF_ASSERT_NXT(a_last_byte, state_q == S_BYTE && byte_last,
                  state_q == S_IDLE && res_valid_q && res_q.last,
                  "final popped byte not marked last")

endmodule

// ===== hdl/packet_slot_fifo.sv =====
// Top level of the packet slot FIFO: command front end and ring back end.
//
// A ring of SLOTS packet slots, each holding up to MAX_PACKET_BYTES bytes and a
// length. Beats are taken when start is high and busy is low; busy rises only
// when the four-entry command queue is full. The back end takes push beats in
// its idle state; the final beat of a packet yields one result (ok, busy or
// truncated). A pop first reads the slot length from its store, then fetches
// the first byte, then gives one result per cycle from the payload store's
// single read port. A pop of an empty ring, or of a zero-length packet, gives
// a single result. Results appear on res_o for exactly one cycle, marked by
// res_valid_o, and cannot be held off by the receiver.
module packet_slot_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  psf_pkg::in_item_t  in_i,
  output logic               res_valid_o,
  output psf_pkg::out_item_t res_o
);
  import psf_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  psf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  psf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// ===== tb/packet_slot_fifo_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for packet_slot_fifo: scripted beats, then random packet traffic.
module packet_slot_fifo_tb;
  import psf_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 80;
  localparam int TOTAL_BEATS  = 460;

  typedef struct packed {
    in_item_t         item;
    logic             typed;
    status_e          st;
    logic [LEN_W-1:0] len;
  } script_row_t;

  // Rows with typed set carry their one result; the rest go through the ring predictor.
  localparam script_row_t SCRIPT [13] = '{
    {KIND_POP,  8'h00, 1'b0, 1'b0, 1'b1, ST_EMPTY, 7'd0},
    {KIND_PUSH, 8'h00, 1'b1, 1'b0, 1'b0, ST_OK,    7'd0},
    {KIND_PUSH, 8'hFF, 1'b1, 1'b1, 1'b1, ST_OK,    7'd2},
    {KIND_PUSH, 8'hFF, 1'b0, 1'b1, 1'b1, ST_OK,    7'd0},
    {KIND_PUSH, 8'h80, 1'b1, 1'b0, 1'b0, ST_OK,    7'd0},
    {KIND_POP,  8'h00, 1'b0, 1'b0, 1'b0, ST_OK,    7'd0},
    {KIND_PUSH, 8'h7F, 1'b1, 1'b1, 1'b1, ST_OK,    7'd2},
    {KIND_POP,  8'h00, 1'b0, 1'b0, 1'b1, ST_OK,    7'd0},
    {KIND_POP,  8'hFF, 1'b1, 1'b1, 1'b0, ST_OK,    7'd0},
    {KIND_POP,  8'hFF, 1'b1, 1'b1, 1'b1, ST_EMPTY, 7'd0},
    {KIND_PUSH, 8'h55, 1'b0, 1'b0, 1'b0, ST_OK,    7'd0},
    {KIND_PUSH, 8'h01, 1'b1, 1'b1, 1'b1, ST_OK,    7'd1},
    {KIND_POP,  8'hAA, 1'b0, 1'b1, 1'b0, ST_OK,    7'd0}
  };

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  logic      busy;
  in_item_t  in_i   = '0;
  logic      res_valid_o;
  out_item_t res_o;

  // Shadow copy of the ring.
  logic [7:0]       shadow_bytes [SLOTS*MAX_PACKET_BYTES];
  logic [LEN_W-1:0] shadow_len   [SLOTS];
  int unsigned      wr_slot = 0;
  int unsigned      rd_slot = 0;
  int unsigned      occ = 0;
  int unsigned      rx_count = 0;
  bit               rx_active = 1'b0;
  bit               rx_rejected = 1'b0;
  bit               rx_truncated = 1'b0;

  out_item_t step_results[$];
  out_item_t ring_results_due[$];
  int        errors = 0;
  int        cycles = 0;
  int        beats_sent = 0;

  packet_slot_fifo u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic emit_result(status_e st, logic [7:0] b, logic v, logic l, int unsigned len);
    out_item_t r;
    r.status        = st;
    r.out_byte      = b;
    r.byte_valid    = v;
    r.last          = l;
    r.packet_length = LEN_W'(len);
    step_results.push_back(r);
  endtask

  // Work out the results one accepted beat causes and advance the shadow ring.
  task automatic ring_predict(in_item_t it);
    int unsigned base;
    int unsigned plen;
    step_results.delete();
    if (it.kind == KIND_PUSH) begin
      if (!rx_active) begin
        rx_active    = 1'b1;
        rx_rejected  = (occ >= SLOTS);
        rx_truncated = 1'b0;
        rx_count     = 0;
      end
      if (it.has_byte && !rx_rejected) begin
        if (rx_count < MAX_PACKET_BYTES) begin
          shadow_bytes[wr_slot*MAX_PACKET_BYTES + rx_count] = it.data_byte;
          rx_count++;
        end else begin
          rx_truncated = 1'b1;
        end
      end
      if (it.last_byte) begin
        rx_active = 1'b0;
        if (rx_rejected) begin
          emit_result(ST_BUSY, 8'h00, 1'b0, 1'b1, 0);
        end else begin
          shadow_len[wr_slot] = LEN_W'(rx_count);
          wr_slot = (wr_slot + 1) % SLOTS;
          occ++;
          emit_result(rx_truncated ? ST_TRUNC : ST_OK, 8'h00, 1'b0, 1'b1, rx_count);
        end
      end
    end else if (occ == 0) begin
      emit_result(ST_EMPTY, 8'h00, 1'b0, 1'b1, 0);
    end else begin
      base    = rd_slot * MAX_PACKET_BYTES;
      plen    = shadow_len[rd_slot];
      rd_slot = (rd_slot + 1) % SLOTS;
      occ--;
      if (plen == 0) begin
        emit_result(ST_OK, 8'h00, 1'b0, 1'b1, 0);
      end else begin
        for (int i = 0; i < plen; i++)
          emit_result(ST_OK, shadow_bytes[base + i], 1'b1, logic'(i + 1 == plen), plen);
      end
    end
  endtask

  // Offer one beat, hold it until taken, then queue what it should produce.
  task automatic send_beat(in_item_t it, int idle_pct, bit typed = 1'b0, out_item_t want = '0);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= it;
    do @(posedge clk_i); while (busy);
    ring_predict(it);
    if (typed) begin
      ring_results_due.push_back(want);
    end else begin
      foreach (step_results[k]) ring_results_due.push_back(step_results[k]);
    end
    beats_sent++;
  endtask

  function automatic in_item_t pop_item();
    return in_item_t'({KIND_POP, 8'($urandom), 1'($urandom), 1'($urandom)});
  endfunction

  // Mostly short packets, some filling a slot exactly, a few running past it.
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 70) return $urandom_range(1, 6);
    if (r < 85) return $urandom_range(7, 30);
    if (r < 93) return MAX_PACKET_BYTES;
    return $urandom_range(MAX_PACKET_BYTES + 1, MAX_PACKET_BYTES + 6);
  endfunction

  // One packet of nbytes payload beats, with no-byte beats and pops cut in at random.
  task automatic send_packet(int nbytes, int idle_pct, int cut_in_pct);
    in_item_t it;
    for (int k = 0; k < nbytes; k++) begin
      if ($urandom_range(99) < 10)
        send_beat(in_item_t'({KIND_PUSH, 8'($urandom), 1'b0, 1'b0}), idle_pct);
      if ($urandom_range(99) < cut_in_pct)
        send_beat(pop_item(), idle_pct);
      it = in_item_t'({KIND_PUSH, 8'($urandom), 1'b1, logic'(k == nbytes - 1)});
      send_beat(it, idle_pct);
    end
    if (nbytes == 0)
      send_beat(in_item_t'({KIND_PUSH, 8'($urandom), 1'b0, 1'b1}), idle_pct);
  endtask

  task automatic run_traffic(int until_beats, int idle_pct, int pop_pct);
    while (beats_sent < until_beats) begin
      if ($urandom_range(99) < pop_pct)
        send_beat(pop_item(), idle_pct);
      else
        send_packet(pick_length(), idle_pct, 5);
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && res_valid_o) begin
      if (ring_results_due.size() == 0) begin
        $error("unexpected result beat: status %0d, out_byte %0h, packet_length %0d",
               res_o.status, res_o.out_byte, res_o.packet_length);
        errors++;
      end else begin
        want = ring_results_due.pop_front();
        if (res_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_o.status);
          errors++;
        end
        if (res_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, res_o.out_byte);
          errors++;
        end
        if (res_o.byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %0b, got %0b", want.byte_valid, res_o.byte_valid);
          errors++;
        end
        if (res_o.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, res_o.last);
          errors++;
        end
        if (res_o.packet_length !== want.packet_length) begin
          $error("packet_length: expected %0d, got %0d", want.packet_length,
                 res_o.packet_length);
          errors++;
        end
      end
    end
  end

  initial begin
    out_item_t want;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (SCRIPT[r]) begin
      want.status        = SCRIPT[r].st;
      want.out_byte      = 8'h00;
      want.byte_valid    = 1'b0;
      want.last          = 1'b1;
      want.packet_length = SCRIPT[r].len;
      send_beat(SCRIPT[r].item, 0, SCRIPT[r].typed, want);
    end

    run_traffic(140, 0, 30);

    // Fill the ring, then offer packets that a full ring must turn away.
    while (occ < SLOTS)
      send_packet($urandom_range(0, 2), 48, 0);
    repeat (4) send_packet($urandom_range(0, 3), 48, 30);

    run_traffic(400, 13, 65);
    run_traffic(TOTAL_BEATS, 0, 35);

    start <= 1'b0;
    while (ring_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/psf_pkg.sv
hdl/psf_front.sv
hdl/psf_back.sv
hdl/packet_slot_fifo.sv
tb/packet_slot_fifo_tb.sv
